FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg
// shared constants and types of the sequenced ring queue
// ----------------------------------------------------------------------------
package srq_pkg;

    // slot count, a power of two so that the slot index is the low position bits
    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int WORD_W      = 64;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [WORD_W-1:0]  push_word;
    } req_beat_t;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  pop_word;
    } rsp_beat_t;

    // one request to both slot memories, shared address
    typedef struct packed {
        logic                   rd_en;
        logic                   seq_wr;
        logic                   data_wr;
        logic [IDX_W-1:0]       addr;
        logic [COUNT_WIDTH-1:0] seq;
        logic [DATA_WIDTH-1:0]  data;
    } mem_req_t;

endpackage

FILE: hw/rtl/srq_ram.sv
// ----------------------------------------------------------------------------
// srq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module srq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/srq_engine.sv
// ----------------------------------------------------------------------------
// srq_engine
// position counters, sequence valid bits and read-modify-write sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srq_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  srq_pkg::req_beat_t                   req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output srq_pkg::rsp_beat_t                   rsp,
    output srq_pkg::mem_req_t                    mem_req,
    input  logic [srq_pkg::COUNT_WIDTH-1:0]      seq_rdata,
    input  logic [srq_pkg::DATA_WIDTH-1:0]       data_rdata
);

    srq_pkg::state_t                     state_reg, state_next;
    srq_pkg::func_t                      op_reg;
    logic [srq_pkg::DATA_WIDTH-1:0]      word_reg;
    logic [srq_pkg::IDX_W-1:0]           idx_reg;
    logic [srq_pkg::COUNT_WIDTH-1:0]     prod_reg, prod_next;
    logic [srq_pkg::COUNT_WIDTH-1:0]     cons_reg, cons_next;
    logic [srq_pkg::DEPTH-1:0]           seq_vld_reg, seq_vld_next;
    srq_pkg::rsp_beat_t                  rsp_reg, rsp_next;
    logic                                rsp_valid_reg, rsp_valid_next;

    logic                                accept;
    logic                                load;
    logic [srq_pkg::IDX_W-1:0]           rd_idx;
    logic [srq_pkg::COUNT_WIDTH-1:0]     cur_seq;
    logic [srq_pkg::COUNT_WIDTH-1:0]     cons_inc;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == srq_pkg::S_IDLE);
    assign rd_idx    = (req.func == srq_pkg::FUNC_POP) ? cons_reg[srq_pkg::IDX_W-1:0]
                                                       : prod_reg[srq_pkg::IDX_W-1:0];
    // never-written entries read as their reset value, the slot index
    assign cur_seq   = seq_vld_reg[idx_reg] ? seq_rdata
                                            : srq_pkg::COUNT_WIDTH'(idx_reg);
    assign cons_inc  = cons_reg + srq_pkg::COUNT_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srq_pkg::S_IDLE;
            prod_reg      <= '0;
            cons_reg      <= '0;
            seq_vld_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_reg      <= prod_next;
            cons_reg      <= cons_next;
            seq_vld_reg   <= seq_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.func;
            word_reg <= req.push_word[srq_pkg::DATA_WIDTH-1:0];
            idx_reg  <= rd_idx;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        cons_next      = cons_reg;
        seq_vld_next   = seq_vld_reg;
        rsp_next       = '{status: srq_pkg::ST_OK, pop_word: '0};
        load           = 1'b0;
        mem_req        = '0;
        mem_req.addr   = idx_reg;
        mem_req.data   = word_reg;

        case (state_reg)
            srq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = rd_idx;
                    state_next    = srq_pkg::S_EXEC;
                end
            end
            srq_pkg::S_EXEC:
            begin
                // wait for the output register to free up
                if (!rsp_valid_reg || rsp_ready)
                begin
                    load       = 1'b1;
                    state_next = srq_pkg::S_IDLE;
                    if (op_reg == srq_pkg::FUNC_PUSH)
                    begin
                        if (word_reg == '0)
                        begin
                            rsp_next.status = srq_pkg::ST_ZERO;
                        end
                        else if (cur_seq == prod_reg)
                        begin
                            mem_req.seq_wr        = 1'b1;
                            mem_req.data_wr       = 1'b1;
                            mem_req.seq           = prod_reg + srq_pkg::COUNT_WIDTH'(1);
                            seq_vld_next[idx_reg] = 1'b1;
                            prod_next             = prod_reg + srq_pkg::COUNT_WIDTH'(1);
                        end
                        else
                        begin
                            rsp_next.status = srq_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        if (cur_seq == cons_inc)
                        begin
                            mem_req.seq_wr        = 1'b1;
                            mem_req.seq           = cons_reg
                                                  + srq_pkg::COUNT_WIDTH'(srq_pkg::DEPTH);
                            seq_vld_next[idx_reg] = 1'b1;
                            cons_next             = cons_inc;
                            rsp_next.pop_word     = srq_pkg::WORD_W'(data_rdata);
                        end
                        else
                        begin
                            rsp_next.status = srq_pkg::ST_EMPTY;
                        end
                    end
                end
            end
            default:
            begin
                state_next = srq_pkg::S_IDLE;
            end
        endcase

        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SRQ_ASSERT_IMP(a_wr_in_exec, mem_req.seq_wr, state_reg == srq_pkg::S_EXEC, "slot write outside exec")
    `SRQ_ASSERT_NXT(a_accept_exec, accept, state_reg == srq_pkg::S_EXEC, "accepted beat not executed")
    `SRQ_ASSERT_IMP(a_pop_nonzero, load && op_reg == srq_pkg::FUNC_POP && rsp_next.status == srq_pkg::ST_OK, rsp_next.pop_word != '0, "successful pop returned zero")
    `SRQ_ASSERT_IMP(a_occupancy, 1'b1, (prod_reg - cons_reg) <= srq_pkg::COUNT_WIDTH'(srq_pkg::DEPTH), "occupancy exceeds depth")

endmodule

FILE: hw/rtl/sequenced_ring_queue_top.sv
// ----------------------------------------------------------------------------
// sequenced_ring_queue_top
// bounded ring queue with a sequence number kept per slot
// ----------------------------------------------------------------------------
// Each request beat is a push of a data word or a pop of the oldest word, and
// gives exactly one response beat with a status (ok, full, empty or zero word
// rejected) and, on a successful pop, the word. A push uses slot
// producer_pos mod DEPTH when its sequence equals producer_pos; a pop uses
// slot consumer_pos mod DEPTH when its sequence equals consumer_pos + 1.
// Sequences and payloads live in two synchronous rams with registered read
// data. The accept cycle issues the slot read and enters the exec state,
// which checks the sequence, writes the slot back and loads the response
// register; a new request is accepted only once the engine is back in idle.
// The response register lets the next request be accepted while the
// previous response still waits; a held response stalls the following one
// in its check cycle. No clearing pass is needed after reset: a valid bit
// per slot makes an untouched sequence read as its slot index. DEPTH must
// be a power of two.
// ----------------------------------------------------------------------------
module sequenced_ring_queue_top (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  srq_pkg::req_beat_t req,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output srq_pkg::rsp_beat_t rsp
);

    // shared slot address and write strobes for both rams
    srq_pkg::mem_req_t                mem_req;
    logic [srq_pkg::COUNT_WIDTH-1:0]  seq_rdata;
    logic [srq_pkg::DATA_WIDTH-1:0]   data_rdata;

    // control: counters, valid bits, check and write-back
    srq_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mem_req    (mem_req),
        .seq_rdata  (seq_rdata),
        .data_rdata (data_rdata)
    );

    // per-slot sequence numbers
    srq_ram #(
        .WIDTH (srq_pkg::COUNT_WIDTH),
        .DEPTH (srq_pkg::DEPTH)
    ) u_seq_ram (
        .clk     (clk),
        .wr_en   (mem_req.seq_wr),
        .wr_addr (mem_req.addr),
        .wr_data (mem_req.seq),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.addr),
        .rd_data (seq_rdata)
    );

    // per-slot payload words, written only by a successful push
    srq_ram #(
        .WIDTH (srq_pkg::DATA_WIDTH),
        .DEPTH (srq_pkg::DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (mem_req.data_wr),
        .wr_addr (mem_req.addr),
        .wr_data (mem_req.data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.addr),
        .rd_data (data_rdata)
    );

endmodule
